// ===== design/wctd_pkg.sv =====
package wctd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_CLASSES = 3;
	localparam int TAG_WIDTH = 16;
	localparam int MAX_RESULTS = 4;

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
	localparam int AW = $clog2(STORE_DEPTH);

	localparam int ACT_W = 7;
	localparam int FRAC_W = 12;
	localparam int DVD_W = ACT_W + 1 + FRAC_W;
	localparam int BITS_PER_STEP = 4;
	localparam int DIV_STEPS = DVD_W / BITS_PER_STEP;
	localparam int DEV_W = 16;

	localparam logic [ACT_W-1:0] CNT_MAX = '1;
	localparam logic [DVD_W-1:0] ONE_Q = DVD_W'(1) << FRAC_W;
	localparam logic [DVD_W-1:0] DEV_SAT = DVD_W'(17'h0FFFF);

	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;
	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	localparam logic [1:0] REG_NUM_THREADS = 2'd0;
	localparam logic [1:0] REG_LIGHT_LIMIT = 2'd1;
	localparam logic [1:0] REG_MIDDLE_LIMIT = 2'd2;
	localparam logic [1:0] REG_HEAVY_LIMIT = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EVAL = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_PICK = 6'b001000,
		ST_MEM  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef struct packed {
		logic                 kind;
		logic [1:0]           cls;
		logic [TAG_WIDTH-1:0] tag;
	} result_t;

	function automatic logic [DEV_W-1:0] dev_of(input logic [DVD_W-1:0] q);
		logic [DVD_W-1:0] r;
		r = (q > ONE_Q) ? (q - ONE_Q) : (ONE_Q - q);
		return (r > DEV_SAT) ? DEV_W'(DEV_SAT) : r[DEV_W-1:0];
	endfunction

endpackage

// ===== design/weighted_class_task_dispatcher_core.sv =====
// Weighted class task dispatcher.
// The task channel (task_valid/task_ready) takes one word per item: func selects an
// enqueue of task_tag into the FIFO of task_class, or the completion of a task of
// that class. After every item the block dispatches queued tasks one at a time
// while a class is eligible, at most four results per item, each leaving on the
// result channel (res_valid/res_ready) with kind, out_class, out_tag and last.
// An enqueue into a full FIFO or into class 3 yields a rejected word first. The
// last word of an item carries last; an item that causes no result gives no word.
// Each dispatch runs six divisions on one shared radix-16 divider, plus selection
// and the FIFO memory read; task_ready is high only between items. A result word
// waits in an output register and one more holding register, so a stall on
// res_ready holds the sequencer until space frees. Reset clears all counts, FIFO
// pointers and restores the default limits; FIFO contents are not cleared.
// Limits are written through the APB port; the user must write them only while
// idle, as the block itself does not enforce it.
module weighted_class_task_dispatcher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           task_valid,
	output logic                           task_ready,
	input  logic                           func,
	input  logic [1:0]                     task_class,
	input  logic [wctd_pkg::TAG_WIDTH-1:0] task_tag,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic                           kind,
	output logic [1:0]                     out_class,
	output logic [wctd_pkg::TAG_WIDTH-1:0] out_tag,
	output logic                           last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import wctd_pkg::*;

	state_t state_q;

	logic [ACT_W-1:0] num_threads_q;
	logic [ACT_W-1:0] limit_q [NUM_CLASSES];
	logic [QW-1:0]    head_q [NUM_CLASSES];
	logic [CW-1:0]    pend_q [NUM_CLASSES];
	logic [ACT_W-1:0] act_q [NUM_CLASSES];
	logic [ACT_W-1:0] total_q;

	logic [TAG_WIDTH-1:0] store_q [STORE_DEPTH];
	logic [TAG_WIDTH-1:0] rdata_q;

	result_t    hold_q;
	logic       hold_v_q;
	result_t    out_q;
	logic       out_last_q;
	logic       out_v_q;
	logic [2:0] nres_q;

	logic [DVD_W-1:0] dvd_q;
	logic [ACT_W:0]   rem_q;
	logic [ACT_W-1:0] dsr_q;
	logic [2:0]       step_q;
	logic [1:0]       dcls_q;
	logic             dplus_q;
	logic [DEV_W-1:0] cur_q [NUM_CLASSES];
	logic [DEV_W-1:0] new_q [NUM_CLASSES];
	logic [1:0]       pick_q;

	logic                 in_acc;
	logic                 cfg_wr;
	logic                 out_free;
	logic                 out_load;
	logic                 overloaded;
	logic [NUM_CLASSES-1:0] elig;
	logic                 enq_ok;
	logic [CW-1:0]        slot_sum;
	logic [QW-1:0]        slot;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [DVD_W-1:0]     dvd_nx;
	logic [ACT_W:0]       rem_nx;
	logic [1:0]           pick_c;
	logic signed [DEV_W+1:0] best;
	logic signed [DEV_W+1:0] delta;
	logic                 found;
	logic [1:0]           ld_cls;
	logic                 ld_plus;
	logic [ACT_W:0]       ld_act;
	logic [ACT_W-1:0]     ld_dsr;
	logic [DEV_W-1:0]     dev_res;
	logic [QW-1:0]        head_nx;

	assign in_acc = task_valid && task_ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign out_free = !out_v_q || res_ready;
	assign out_load = hold_v_q && out_free && ((state_q == ST_MEM) || (state_q == ST_FIN));
	assign task_ready = (state_q == ST_IDLE);
	assign res_valid = out_v_q;
	assign kind = out_q.kind;
	assign out_class = out_q.cls;
	assign out_tag = out_q.tag;
	assign last = out_last_q;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_NUM_THREADS:  prdata[ACT_W-1:0] = num_threads_q;
			REG_LIGHT_LIMIT:  prdata[ACT_W-1:0] = limit_q[0];
			REG_MIDDLE_LIMIT: prdata[ACT_W-1:0] = limit_q[1];
			REG_HEAVY_LIMIT:  prdata[ACT_W-1:0] = limit_q[2];
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		overloaded = (total_q >= num_threads_q);
		for (int c = 0; c < NUM_CLASSES; c++) begin
			elig[c] = (pend_q[c] != '0) && (!overloaded || (act_q[c] < limit_q[c]));
		end
	end

	always_comb begin
		enq_ok = 1'b0;
		slot_sum = '0;
		if (task_class < 2'(NUM_CLASSES)) begin
			enq_ok = (pend_q[task_class] < CW'(QUEUE_DEPTH));
			slot_sum = CW'(head_q[task_class]) + pend_q[task_class];
		end
		if (slot_sum >= CW'(QUEUE_DEPTH)) begin
			slot = QW'(slot_sum - CW'(QUEUE_DEPTH));
		end else begin
			slot = QW'(slot_sum);
		end
		wr_addr = AW'(AW'(task_class) * AW'(QUEUE_DEPTH)) + AW'(slot);
	end

	always_comb begin
		dvd_nx = dvd_q;
		rem_nx = rem_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			rem_nx = {rem_nx[ACT_W-1:0], dvd_nx[DVD_W-1]};
			dvd_nx = {dvd_nx[DVD_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, dsr_q}) begin
				rem_nx = rem_nx - {1'b0, dsr_q};
				dvd_nx[0] = 1'b1;
			end
		end
		dev_res = dev_of(dvd_nx);
	end

	always_comb begin
		if (state_q == ST_EVAL) begin
			ld_cls = 2'd0;
			ld_plus = 1'b0;
		end else if (dplus_q) begin
			ld_cls = (dcls_q == 2'(NUM_CLASSES - 1)) ? 2'd0 : dcls_q + 2'd1;
			ld_plus = 1'b0;
		end else begin
			ld_cls = dcls_q;
			ld_plus = 1'b1;
		end
		ld_act = {1'b0, act_q[ld_cls]} + (ACT_W+1)'(ld_plus);
		ld_dsr = (limit_q[ld_cls] == '0) ? ACT_W'(1) : limit_q[ld_cls];
	end

	always_comb begin
		pick_c = 2'd0;
		best = '0;
		found = 1'b0;
		delta = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			delta = $signed({2'b00, new_q[c]}) - $signed({2'b00, cur_q[c]});
			if (elig[c] && (!found || (delta < best))) begin
				found = 1'b1;
				best = delta;
				pick_c = 2'(c);
			end
		end
		rd_addr = AW'(AW'(pick_c) * AW'(QUEUE_DEPTH)) + AW'(head_q[pick_c]);
		head_nx = (head_q[pick_q] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[pick_q] + QW'(1);
	end

	always_ff @(posedge clk) begin
		if (in_acc && (func == FUNC_ENQUEUE) && enq_ok) begin
			store_q[wr_addr] <= task_tag;
		end
		if (state_q == ST_PICK) begin
			rdata_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EVAL) || ((state_q == ST_DIV) && (step_q == 3'(DIV_STEPS - 1)))) begin
			dvd_q <= {ld_act, FRAC_W'(0)};
			rem_q <= '0;
			dsr_q <= ld_dsr;
		end else begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
		if ((state_q == ST_DIV) && (step_q == 3'(DIV_STEPS - 1))) begin
			if (dplus_q) begin
				new_q[dcls_q] <= dev_res;
			end else begin
				cur_q[dcls_q] <= dev_res;
			end
		end
		if (state_q == ST_PICK) begin
			pick_q <= pick_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_threads_q <= ACT_W'(4);
			limit_q[0] <= ACT_W'(3);
			limit_q[1] <= ACT_W'(2);
			limit_q[2] <= ACT_W'(1);
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				pend_q[c] <= '0;
				act_q[c] <= '0;
			end
			total_q <= '0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
			nres_q <= '0;
			step_q <= '0;
			dcls_q <= '0;
			dplus_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_NUM_THREADS:  num_threads_q <= pwdata[ACT_W-1:0];
					REG_LIGHT_LIMIT:  limit_q[0] <= pwdata[ACT_W-1:0];
					REG_MIDDLE_LIMIT: limit_q[1] <= pwdata[ACT_W-1:0];
					REG_HEAVY_LIMIT:  limit_q[2] <= pwdata[ACT_W-1:0];
					default:          num_threads_q <= num_threads_q;
				endcase
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (func == FUNC_ENQUEUE) begin
							if (enq_ok) begin
								pend_q[task_class] <= pend_q[task_class] + CW'(1);
								nres_q <= '0;
							end else begin
								hold_q <= '{kind: KIND_REJECT, cls: task_class, tag: task_tag};
								hold_v_q <= 1'b1;
								nres_q <= 3'd1;
							end
						end else begin
							nres_q <= '0;
							if (task_class < 2'(NUM_CLASSES)) begin
								if (act_q[task_class] != '0) begin
									act_q[task_class] <= act_q[task_class] - ACT_W'(1);
								end
								if (total_q != '0) begin
									total_q <= total_q - ACT_W'(1);
								end
							end
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if ((nres_q == 3'(MAX_RESULTS)) || (elig == '0)) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= '0;
						dcls_q <= 2'd0;
						dplus_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == 3'(DIV_STEPS - 1)) begin
						step_q <= '0;
						if (dplus_q && (dcls_q == 2'(NUM_CLASSES - 1))) begin
							state_q <= ST_PICK;
						end else begin
							dcls_q <= ld_cls;
							dplus_q <= ld_plus;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_PICK: begin
					state_q <= ST_MEM;
				end
				ST_MEM: begin
					if (!hold_v_q || out_free) begin
						if (hold_v_q) begin
							out_q <= hold_q;
							out_last_q <= 1'b0;
						end
						hold_q <= '{kind: KIND_DISPATCH, cls: pick_q, tag: rdata_q};
						hold_v_q <= 1'b1;
						nres_q <= nres_q + 3'd1;
						head_q[pick_q] <= head_nx;
						pend_q[pick_q] <= pend_q[pick_q] - CW'(1);
						if (act_q[pick_q] != CNT_MAX) begin
							act_q[pick_q] <= act_q[pick_q] + ACT_W'(1);
						end
						if (total_q != CNT_MAX) begin
							total_q <= total_q + ACT_W'(1);
						end
						state_q <= ST_EVAL;
					end
				end
				ST_FIN: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q <= hold_q;
						out_last_q <= 1'b1;
						hold_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("holding register occupied while idle");
	a_nres_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= 3'(MAX_RESULTS))
		else $error("result count beyond the per-item limit");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEM) |-> (pend_q[pick_q] != '0))
		else $error("dispatch from an empty FIFO");
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && hold_v_q && out_free) |=> (out_v_q && out_last_q))
		else $error("final word not marked last");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import wctd_pkg::*;

	typedef struct packed {
		logic       fn;
		logic [1:0] cls;
		logic [15:0] tg;
		logic       chk;
		logic       ekind;
		logic [1:0] ecls;
		logic [15:0] etag;
		logic       elast;
	} drow_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] cls;
		logic [15:0] tag;
		logic       last;
	} word_t;

	logic clk, arst_n;
	logic task_valid, task_ready, func;
	logic [1:0] task_class;
	logic [15:0] task_tag;
	logic res_valid, res_ready, kind, last;
	logic [1:0] out_class;
	logic [15:0] out_tag;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	weighted_class_task_dispatcher_core dut (.*);

	logic [6:0] threads_q;
	logic [6:0] limit_q [3];
	logic [15:0] fifo_q [3][$];
	logic [6:0] act_q [3];
	logic [6:0] tot_q;
	word_t expected_words [$];
	int errors = 0;
	int cycles = 0;
	bit hold_req = 0;
	bit held = 0;
	drow_t dir [$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic [31:0] dev_q(logic [7:0] a, logic [6:0] lim);
		logic [31:0] d, q, r;
		d = (lim == 0) ? 1 : lim;
		q = ({24'd0, a} << 12) / d;
		r = (q > 4096) ? q - 4096 : 4096 - q;
		return (r > 65535) ? 65535 : r;
	endfunction

	function automatic void predict_dispatch(logic fn, logic [1:0] cls, logic [15:0] tg);
		int n;
		bit ovl, el [3];
		logic [31:0] cur [3], sum, score, best;
		int cnt, pick;
		word_t w;
		n = 0;
		if (fn == FUNC_ENQUEUE) begin
			if (cls < 3 && fifo_q[cls].size() < QUEUE_DEPTH) fifo_q[cls] = {fifo_q[cls], tg};
			else begin
				w = '{KIND_REJECT, cls, tg, 1'b0};
				expected_words = {expected_words, w};
				n++;
			end
		end else if (cls < 3) begin
			if (act_q[cls] > 0) act_q[cls]--;
			if (tot_q > 0) tot_q--;
		end
		while (n < MAX_RESULTS) begin
			ovl = tot_q >= threads_q;
			cnt = 0;
			sum = 0;
			pick = -1;
			best = 0;
			for (int c = 0; c < 3; c++) begin
				el[c] = fifo_q[c].size() > 0 && (!ovl || act_q[c] < limit_q[c]);
				cur[c] = dev_q(act_q[c], limit_q[c]);
				if (el[c]) begin
					cnt++;
					sum += cur[c];
				end
			end
			if (cnt == 0) break;
			for (int c = 0; c < 3; c++) begin
				if (el[c]) begin
					score = sum - cur[c] + dev_q(act_q[c] + 8'd1, limit_q[c]);
					if (pick < 0 || score < best) begin
						pick = c;
						best = score;
					end
				end
			end
			w = '{KIND_DISPATCH, pick[1:0], fifo_q[pick].pop_front(), 1'b0};
			if (act_q[pick] < 127) act_q[pick]++;
			if (tot_q < 127) tot_q++;
			expected_words = {expected_words, w};
			n++;
		end
		if (n > 0) expected_words[$].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		word_t w;
		if (res_valid && res_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word k=%0d c=%0d t=%h l=%0d", $time, kind,
					out_class, out_tag, last);
				errors++;
			end else begin
				w = expected_words.pop_front();
				if (w != {kind, out_class, out_tag, last}) begin
					$display("%0t: mismatch expected k=%0d c=%0d t=%h l=%0d actual k=%0d c=%0d t=%h l=%0d",
						$time, w.kind, w.cls, w.tag, w.last, kind, out_class, out_tag, last);
					errors++;
				end
			end
		end
	end

	initial begin
		res_ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				res_ready <= 0;
				repeat (400) @(posedge clk);
				held = 1;
			end
			else if (cycles % 700 < 200) res_ready <= 1;
			else res_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [6:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_NUM_THREADS) threads_q = v;
		else limit_q[idx - 1] = v;
	endtask

	task automatic send_word(logic fn, logic [1:0] cls, logic [15:0] tg);
		task_valid <= 1; func <= fn; task_class <= cls; task_tag <= tg;
		@(posedge clk);
		while (!task_ready) @(posedge clk);
		predict_dispatch(fn, cls, tg);
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (expected_words.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic random_burst(int items, int maxclass);
		int b, burst, gap;
		logic fn;
		b = 0;
		while (b < items) begin
			burst = $urandom_range(1, 8);
			for (int i = 0; i < burst && b < items; i++) begin
				fn = ($urandom_range(0, 99) < 55) ? FUNC_ENQUEUE : FUNC_COMPLETE;
				send_word(fn, 2'($urandom_range(0, maxclass)), 16'($urandom));
				b++;
			end
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				task_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		task_valid <= 0;
	endtask

	initial begin
		drow_t r;
		task_valid <= 0; func <= 0; task_class <= 0; task_tag <= 0;
		psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
		arst_n = 0;
		threads_q = 4;
		limit_q = '{7'd3, 7'd2, 7'd1};
		act_q = '{0, 0, 0};
		tot_q = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir = {dir, drow_t'{FUNC_ENQUEUE, 2'd0, 16'h0000, 1'b1,
			KIND_DISPATCH, 2'd0, 16'h0000, 1'b1}};
		dir = {dir, drow_t'{FUNC_ENQUEUE, 2'd2, 16'hFFFF, 1'b1,
			KIND_DISPATCH, 2'd2, 16'hFFFF, 1'b1}};
		dir = {dir, drow_t'{FUNC_ENQUEUE, 2'd3, 16'hA5A5, 1'b1,
			KIND_REJECT, 2'd3, 16'hA5A5, 1'b1}};
		dir = {dir, drow_t'{FUNC_COMPLETE, 2'd3, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0}};
		dir = {dir, drow_t'{FUNC_COMPLETE, 2'd0, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0}};
		dir = {dir, drow_t'{FUNC_COMPLETE, 2'd2, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0}};
		dir = {dir, drow_t'{FUNC_COMPLETE, 2'd1, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0}};
		for (int i = 0; i < 8; i++)
			dir = {dir, drow_t'{FUNC_ENQUEUE, 2'(i % 3), 16'(16'h5A00 + i),
				1'b0, 1'b0, 2'd0, 16'h0, 1'b0}};
		for (int i = 0; i < 6; i++)
			dir = {dir, drow_t'{FUNC_COMPLETE, 2'(i % 3), 16'h0,
				1'b0, 1'b0, 2'd0, 16'h0, 1'b0}};
		foreach (dir[i]) begin
			r = dir[i];
			if (r.chk) begin
				task_valid <= 0;
				@(posedge clk);
				while (expected_words.size() != 0) @(posedge clk);
				send_word(r.fn, r.cls, r.tg);
				if (expected_words.size() != 1) begin
					$display("%0t: directed row %0d expected k=%0d c=%0d t=%h actual %0d words",
						$time, i, r.ekind, r.ecls, r.etag, expected_words.size());
					errors++;
				end else if (expected_words[0] != {r.ekind, r.ecls, r.etag, r.elast}) begin
					$display("%0t: directed row %0d expected k=%0d c=%0d t=%h actual k=%0d c=%0d t=%h",
						$time, i, r.ekind, r.ecls, r.etag, expected_words[0].kind,
						expected_words[0].cls, expected_words[0].tag);
					errors++;
				end
			end else send_word(r.fn, r.cls, r.tg);
		end
		task_valid <= 0;
		drain();

		// Fill every FIFO with no thread free, then overflow it.
		apb_write(REG_NUM_THREADS, 7'd0);
		apb_write(REG_LIGHT_LIMIT, 7'd0);
		apb_write(REG_MIDDLE_LIMIT, 7'd0);
		apb_write(REG_HEAVY_LIMIT, 7'd0);
		for (int i = 0; i < 51; i++) send_word(FUNC_ENQUEUE, 2'(i % 3), 16'($urandom));
		task_valid <= 0;
		drain();
		apb_write(REG_NUM_THREADS, 7'd127);
		hold_req = 1;
		random_burst(20, 3);
		drain();

		apb_write(REG_NUM_THREADS, 7'd1);
		apb_write(REG_LIGHT_LIMIT, 7'd64);
		apb_write(REG_MIDDLE_LIMIT, 7'd127);
		apb_write(REG_HEAVY_LIMIT, 7'd1);
		random_burst(100, 2);
		drain();

		apb_write(REG_NUM_THREADS, 7'd64);
		apb_write(REG_LIGHT_LIMIT, 7'd1);
		apb_write(REG_MIDDLE_LIMIT, 7'd5);
		apb_write(REG_HEAVY_LIMIT, 7'd64);
		random_burst(100, 3);
		drain();

		apb_write(REG_NUM_THREADS, 7'($urandom_range(1, 12)));
		apb_write(REG_LIGHT_LIMIT, 7'($urandom_range(1, 8)));
		apb_write(REG_MIDDLE_LIMIT, 7'($urandom_range(1, 8)));
		apb_write(REG_HEAVY_LIMIT, 7'($urandom_range(1, 8)));
		random_burst(90, 2);
		drain();

		if (errors == 0 && expected_words.size() == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end
endmodule
